[hw/rtl/pdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types, codes and the byte-wide CRC-32 update of the packet deframer.
// ----------------------------------------------------------------------------
package pdf_pkg;

    // Header geometry: 32 big-endian bytes.
    localparam int HEADER_BYTES = 32;
    localparam int HDR_W        = HEADER_BYTES * 8;
    localparam int HCNT_W       = $clog2(HEADER_BYTES);

    localparam logic [31:0] MAGIC_WORD = 32'h4947_4E53;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_TYPE_MASK  = 8'd2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MAGIC    = 3'd1,
        ERR_VERSION  = 3'd2,
        ERR_TYPE     = 3'd3,
        ERR_TOO_LONG = 3'd4,
        ERR_CRC      = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } t_phase;

    // Header layout, first received byte in the top bits.
    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  ptype;
        logic [15:0] flags;
        logic [31:0] length;
        logic [63:0] seq;
        logic [63:0] ts;
        logic [31:0] crc;
    } t_header;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pbyte;
        logic        last;
        logic [7:0]  ptype;
        logic [15:0] flags;
        logic [31:0] length;
        logic [63:0] seq;
        logic [63:0] ts;
        t_err        err;
    } t_result;

    // Up to two results written by one received byte.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [7:0]  version;
        logic [31:0] max_payload;
        logic [63:0] type_mask;
    } t_config;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

[hw/rtl/packet_deframer_crc_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_deframer_crc_check
// Byte-stream packet deframer with header checks and payload CRC-32 check.
// ----------------------------------------------------------------------------
// Each accepted byte is registered at the input; its results go to the result queue.
// Throughput: one byte per cycle when not stalled; the final payload byte yields two
// results, which the queue delivers one per cycle unless the result side stalls.
// Input is stalled while queued results plus the byte in flight exceed RESULT_DEPTH-2.
// Reset is synchronous, active low; it restores the register defaults and
// clears any latched error.
module packet_deframer_crc_check
    import pdf_pkg::*;
#(
    parameter int RESULT_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Received byte stream
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    input  logic [7:0]            i_rx_byte,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Results
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [1:0]            o_result_kind,
    output logic [7:0]            o_payload_byte,
    output logic                  o_last,
    output logic [7:0]            o_packet_type,
    output logic [15:0]           o_packet_flags,
    output logic [31:0]           o_body_length,
    output logic [63:0]           o_sequence_number,
    output logic [63:0]           o_timestamp_ns,
    output logic [2:0]            o_error_code
);

    localparam int LVL_W = $clog2(RESULT_DEPTH + 1);

    t_config              r_cfg;
    t_push                push;
    t_result              head;
    logic [LVL_W-1:0]     level;
    logic                 in_flight;
    logic                 rx_accept;

    // Configuration registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version     <= 8'd1;
            r_cfg.max_payload <= 32'd1048576;
            r_cfg.type_mask   <= 64'h1_FFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROTOCOL_VERSION: r_cfg.version     <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD:      r_cfg.max_payload <= i_cfg_data[31:0];
                CFG_KNOWN_TYPE_MASK:  r_cfg.type_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Room for two results of the new byte and one of the byte in flight is kept.
    assign o_rx_stall = ((LVL_W+1)'(level) + (LVL_W+1)'(in_flight))
                        > (LVL_W+1)'(RESULT_DEPTH - 2);
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    pdf_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (rx_accept),
        .i_in_byte   (i_rx_byte),
        .o_in_flight (in_flight),
        .o_push      (push)
    );

    pdf_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_level (level),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_head  (head)
    );

    assign o_result_kind     = head.kind;
    assign o_payload_byte    = head.pbyte;
    assign o_last            = head.last;
    assign o_packet_type     = head.ptype;
    assign o_packet_flags    = head.flags;
    assign o_body_length     = head.length;
    assign o_sequence_number = head.seq;
    assign o_timestamp_ns    = head.ts;
    assign o_error_code      = head.err;

endmodule

[hw/rtl/pdf_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_result_fifo
// Small result queue: up to two results in a cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module pdf_result_fifo
    import pdf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_push                        i_push,
    output logic [$clog2(DEPTH+1)-1:0]   o_level,
    output logic                         o_valid,
    input  logic                         i_stall,
    output t_result                      o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0]   r_level, n_level;
    logic [PTR_W-1:0]   wr_ptr_2nd;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop        = (r_level != '0) && !i_stall;
    assign wr_ptr_2nd = ptr_inc(r_wr_ptr);

    // Pointer and fill level bookkeeping.
    always_comb begin
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        unique case (i_push.num)
            2'd1:    n_wr_ptr = wr_ptr_2nd;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr_2nd);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_level = r_level + LVL_W'(i_push.num) - LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Entry storage; the second result goes to the slot after the first.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push.num != 2'd0 && r_wr_ptr == PTR_W'(i)) begin
                r_mem[i] <= i_push.first;
            end else if (i_push.num == 2'd2 && wr_ptr_2nd == PTR_W'(i)) begin
                r_mem[i] <= i_push.second;
            end
        end
    end

    assign o_level = r_level;
    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // The queue must never be written beyond its depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LVL_W+1)'(r_level) + (LVL_W+1)'(i_push.num) - (LVL_W+1)'(pop) <= (LVL_W+1)'(DEPTH))
        else $error("result queue overflow");

    // A delivered result leaves the level one lower unless new ones arrive.
    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.num == 2'd0) |=> (r_level == $past(r_level) - 1'b1))
        else $error("result queue level lost track");

    // The fill level never exceeds the depth.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(DEPTH))
        else $error("result queue level out of range");

endmodule

[hw/rtl/pdf_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_deframer
// Header gathering and checks, payload pass-through and CRC-32 verification.
// ----------------------------------------------------------------------------
module pdf_deframer
    import pdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_config     i_cfg,
    input  logic        i_in_valid,
    input  logic [7:0]  i_in_byte,
    output logic        o_in_flight,
    output t_push       o_push
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    t_phase             r_phase, n_phase;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    logic [HDR_W-1:0]   r_hdr, n_hdr;
    logic [31:0]        r_left, n_left;
    logic [31:0]        r_crc, n_crc;

    logic [HDR_W-1:0]   hdr_shift;
    t_header            hdr_new;
    t_header            hdr_held;
    logic               hdr_done;
    t_err               hdr_err;
    logic               type_ok;
    logic               zero_crc_ok;
    logic [31:0]        crc_next;
    logic               pay_end;
    logic               crc_ok;

    function automatic t_result make_simple(input t_kind k, input logic [7:0] b,
                                            input logic l, input t_err e);
        t_result r;
        r       = '0;
        r.kind  = k;
        r.pbyte = b;
        r.last  = l;
        r.err   = e;
        return r;
    endfunction

    function automatic t_result make_complete(input t_header h);
        t_result r;
        r        = '0;
        r.kind   = KIND_COMPLETE;
        r.last   = 1'b1;
        r.ptype  = h.ptype;
        r.flags  = h.flags;
        r.length = h.length;
        r.seq    = h.seq;
        r.ts     = h.ts;
        r.err    = ERR_NONE;
        return r;
    endfunction

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign o_in_flight = r_in_valid;

    // Header view with the current byte shifted in, and the held header.
    assign hdr_shift = {r_hdr[HDR_W-9:0], r_in_byte};
    assign hdr_new   = t_header'(hdr_shift);
    assign hdr_held  = t_header'(r_hdr);
    assign hdr_done  = (r_hcnt == HCNT_W'(HEADER_BYTES - 1));

    // Header checks in priority order.
    assign type_ok = (hdr_new.ptype[7:6] == 2'd0) && i_cfg.type_mask[hdr_new.ptype[5:0]];

    always_comb begin
        priority if (hdr_new.magic != MAGIC_WORD) begin
            hdr_err = ERR_MAGIC;
        end else if (hdr_new.version != i_cfg.version) begin
            hdr_err = ERR_VERSION;
        end else if (!type_ok) begin
            hdr_err = ERR_TYPE;
        end else if (hdr_new.length > i_cfg.max_payload) begin
            hdr_err = ERR_TOO_LONG;
        end else begin
            hdr_err = ERR_NONE;
        end
    end

    // An empty payload leaves the CRC at its initial value.
    assign zero_crc_ok = (hdr_new.crc == ~CRC_INIT);
    assign crc_next    = crc_byte(r_crc, r_in_byte);
    assign pay_end     = (r_left == 32'd1);
    assign crc_ok      = (~crc_next == hdr_held.crc);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (r_in_valid) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (hdr_done) begin
                        if (hdr_err != ERR_NONE) begin
                            n_phase = PH_HALTED;
                        end else if (hdr_new.length == 32'd0) begin
                            n_phase = zero_crc_ok ? PH_HEADER : PH_HALTED;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (pay_end) begin
                        n_phase = crc_ok ? PH_HEADER : PH_HALTED;
                    end
                end
                PH_HALTED: begin
                    n_phase = PH_HALTED;
                end
                default: begin
                    n_phase = PH_HALTED;
                end
            endcase
        end
    end

    // Datapath updates and result generation.
    always_comb begin
        n_hcnt = r_hcnt;
        n_hdr  = r_hdr;
        n_left = r_left;
        n_crc  = r_crc;
        o_push = '0;
        if (r_in_valid) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr  = hdr_shift;
                    n_hcnt = r_hcnt + 1'b1;
                    if (hdr_done) begin
                        n_hcnt = '0;
                        n_crc  = CRC_INIT;
                        o_push.num = 2'd1;
                        if (hdr_err != ERR_NONE) begin
                            o_push.first = make_simple(KIND_ERROR, 8'd0, 1'b1, hdr_err);
                        end else if (hdr_new.length == 32'd0) begin
                            o_push.first = zero_crc_ok ? make_complete(hdr_new)
                                         : make_simple(KIND_ERROR, 8'd0, 1'b1, ERR_CRC);
                        end else begin
                            o_push.num = 2'd0;
                            n_left     = hdr_new.length;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left = r_left - 1'b1;
                    n_crc  = crc_next;
                    if (pay_end) begin
                        n_crc         = CRC_INIT;
                        o_push.num    = 2'd2;
                        o_push.first  = make_simple(KIND_PAYLOAD, r_in_byte, 1'b0, ERR_NONE);
                        o_push.second = crc_ok ? make_complete(hdr_held)
                                      : make_simple(KIND_ERROR, 8'd0, 1'b1, ERR_CRC);
                    end else begin
                        o_push.num    = 2'd1;
                        o_push.first  = make_simple(KIND_PAYLOAD, r_in_byte, 1'b1, ERR_NONE);
                    end
                end
                PH_HALTED: begin
                    o_push.num = 2'd0;
                end
                default: begin
                    o_push.num = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= '0;
            r_left  <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_left  <= n_left;
            r_crc   <= n_crc;
        end
    end

    // The header shift register needs no reset: it is refilled before each use.
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    // Once an error has been reported nothing more is produced.
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALTED) |-> (o_push.num == 2'd0))
        else $error("result produced after a latched error");

    // Throughout the payload the header counter rests at zero and bytes remain.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_hcnt == '0 && r_left != 32'd0))
        else $error("header count or length inconsistent in payload");

    // Two results only at the end of a payload: a byte and then the packet end.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |-> (o_push.first.kind == KIND_PAYLOAD && !o_push.first.last
                                  && o_push.second.last))
        else $error("malformed result pair");

endmodule

[tb/deframer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, configuration and result channels of the packet
// deframer, predicts every result from its own copy of the framing state and
// compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module deframer_checker
    import pdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    input  logic                  i_rx_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [1:0]            i_result_kind,
    input  logic [7:0]            i_payload_byte,
    input  logic                  i_last,
    input  logic [7:0]            i_packet_type,
    input  logic [15:0]           i_packet_flags,
    input  logic [31:0]           i_body_length,
    input  logic [63:0]           i_sequence_number,
    input  logic [63:0]           i_timestamp_ns,
    input  logic [2:0]            i_error_code,
    output int                    o_mismatches,
    output int                    o_pending
);

    // Register copies.
    logic [7:0]     want_version;
    logic [31:0]    len_limit;
    logic [63:0]    type_mask;

    // Framing state.
    logic [HDR_W-1:0] hdr_bits;
    int unsigned      hdr_cnt;
    logic             in_body;
    logic [31:0]      body_left;
    logic [31:0]      crc_acc;
    t_err             sticky_err;

    t_result awaited[$];
    int      mismatches;

    // Reflected CRC-32, one bit per step, least significant bit first.
    function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf({"kind=%0d byte=%02h last=%0b type=%02h flags=%04h len=%08h",
                          " seq=%016h ts=%016h err=%0d"},
                         r.kind, r.pbyte, r.last, r.ptype, r.flags, r.length,
                         r.seq, r.ts, r.err);
    endfunction

    // Closes a frame: the complete item when the CRC matches, else a CRC error.
    task automatic close_frame();
        t_header h;
        t_result r;
        h = hdr_bits;
        r = '0;
        r.last = 1'b1;
        if (~crc_acc == h.crc) begin
            r.kind   = KIND_COMPLETE;
            r.ptype  = h.ptype;
            r.flags  = h.flags;
            r.length = h.length;
            r.seq    = h.seq;
            r.ts     = h.ts;
            r.err    = ERR_NONE;
        end else begin
            r.kind     = KIND_ERROR;
            r.err      = ERR_CRC;
            sticky_err = ERR_CRC;
        end
        awaited.insert(awaited.size(), r);
        in_body   = 1'b0;
        body_left = '0;
        crc_acc   = CRC_INIT;
    endtask

    // Advances the framing state by one received byte and queues its results.
    task automatic deframe_byte(input logic [7:0] b);
        t_header h;
        t_result r;
        t_err    fault;
        if (sticky_err == ERR_NONE) begin
            if (in_body) begin
                crc_acc   = crc32_feed(crc_acc, b);
                body_left = body_left - 32'd1;
                r         = '0;
                r.kind    = KIND_PAYLOAD;
                r.pbyte   = b;
                r.last    = (body_left != 0);
                r.err     = ERR_NONE;
                awaited.insert(awaited.size(), r);
                if (body_left == 0) begin
                    close_frame();
                end
            end else begin
                hdr_bits = {hdr_bits[HDR_W-9:0], b};
                hdr_cnt++;
                if (hdr_cnt == HEADER_BYTES) begin
                    hdr_cnt = 0;
                    h       = hdr_bits;
                    fault   = ERR_NONE;
                    if (h.magic != MAGIC_WORD) begin
                        fault = ERR_MAGIC;
                    end else if (h.version != want_version) begin
                        fault = ERR_VERSION;
                    end else if (h.ptype >= 64 || !type_mask[h.ptype[5:0]]) begin
                        fault = ERR_TYPE;
                    end else if (h.length > len_limit) begin
                        fault = ERR_TOO_LONG;
                    end
                    if (fault != ERR_NONE) begin
                        sticky_err = fault;
                        r          = '0;
                        r.kind     = KIND_ERROR;
                        r.last     = 1'b1;
                        r.err      = fault;
                        awaited.insert(awaited.size(), r);
                    end else begin
                        crc_acc = CRC_INIT;
                        if (h.length == 0) begin
                            close_frame();
                        end else begin
                            in_body   = 1'b1;
                            body_left = h.length;
                        end
                    end
                end
            end
        end
    endtask

    // Compares one delivered result with the oldest prediction.
    task automatic check_result();
        t_result got;
        t_result want;
        got.kind   = t_kind'(i_result_kind);
        got.pbyte  = i_payload_byte;
        got.last   = i_last;
        got.ptype  = i_packet_type;
        got.flags  = i_packet_flags;
        got.length = i_body_length;
        got.seq    = i_sequence_number;
        got.ts     = i_timestamp_ns;
        got.err    = t_err'(i_error_code);
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with nothing awaited: %s", $realtime, describe(got));
            end
        end else begin
            want = awaited.pop_front();
            if (want.kind !== got.kind || want.pbyte !== got.pbyte ||
                want.last !== got.last || want.ptype !== got.ptype ||
                want.flags !== got.flags || want.length !== got.length ||
                want.seq !== got.seq || want.ts !== got.ts || want.err !== got.err) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endtask

    // Results are compared before the byte of the same edge is predicted, as
    // a result can never belong to a request accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            want_version = 8'd1;
            len_limit    = 32'd1048576;
            type_mask    = 64'h1_FFFF;
            hdr_bits     = '0;
            hdr_cnt      = 0;
            in_body      = 1'b0;
            body_left    = '0;
            crc_acc      = CRC_INIT;
            sticky_err   = ERR_NONE;
            mismatches   = 0;
            awaited.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROTOCOL_VERSION: begin
                        want_version = i_cfg_data[7:0];
                    end
                    CFG_MAX_PAYLOAD: begin
                        len_limit = i_cfg_data[31:0];
                    end
                    CFG_KNOWN_TYPE_MASK: begin
                        type_mask = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_rx_valid && !i_rx_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= awaited.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams with correct CRCs through the packet deframer
// under changing register settings and random idling on both channels, ends
// with one broken frame and trailing noise, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench
    import pdf_pkg::*;
();

    localparam int STALL_LIMIT = 2000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  rx_valid    = 1'b0;
    logic                  rx_stall;
    logic [7:0]            rx_byte     = '0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  res_valid;
    logic                  res_stall   = 1'b0;
    logic [1:0]            result_kind;
    logic [7:0]            payload_byte;
    logic                  last_item;
    logic [7:0]            packet_type;
    logic [15:0]           packet_flags;
    logic [31:0]           body_length;
    logic [63:0]           sequence_number;
    logic [63:0]           timestamp_ns;
    logic [2:0]            error_code;

    int chk_mismatches;
    int chk_pending;

    // Stimulus-side copy of the registers, used to build acceptable frames.
    logic [7:0]  cur_version = 8'd1;
    logic [31:0] cur_limit   = 32'd1048576;
    logic [63:0] cur_mask    = 64'h1_FFFF;

    logic [7:0] body_buf[0:511];
    int         bytes_sent  = 0;
    bit         rx_quiet    = 1'b0;
    bit         res_quiet   = 1'b0;
    int         hold_left   = 0;
    int         hold        = 0;
    int         idle_cycles = 0;

    packet_deframer_crc_check u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_rx_valid        (rx_valid),
        .o_rx_stall        (rx_stall),
        .i_rx_byte         (rx_byte),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_res_valid       (res_valid),
        .i_res_stall       (res_stall),
        .o_result_kind     (result_kind),
        .o_payload_byte    (payload_byte),
        .o_last            (last_item),
        .o_packet_type     (packet_type),
        .o_packet_flags    (packet_flags),
        .o_body_length     (body_length),
        .o_sequence_number (sequence_number),
        .o_timestamp_ns    (timestamp_ns),
        .o_error_code      (error_code)
    );

    deframer_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_rx_valid        (rx_valid),
        .i_rx_stall        (rx_stall),
        .i_rx_byte         (rx_byte),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_res_valid       (res_valid),
        .i_res_stall       (res_stall),
        .i_result_kind     (result_kind),
        .i_payload_byte    (payload_byte),
        .i_last            (last_item),
        .i_packet_type     (packet_type),
        .i_packet_flags    (packet_flags),
        .i_body_length     (body_length),
        .i_sequence_number (sequence_number),
        .i_timestamp_ns    (timestamp_ns),
        .i_error_code      (error_code),
        .o_mismatches      (chk_mismatches),
        .o_pending         (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: after each accepted result, stall for a drawn number of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_left <= 0;
        end else if (res_valid && !res_stall) begin
            hold = res_quiet ? 0 : $urandom_range(0, 6);
            hold_left <= hold;
            res_stall <= (hold != 0);
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else begin
            hold_left <= 0;
            res_stall <= 1'b0;
        end
    end

    // Watchdog: too long without any accepted request ends the run.
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one byte after a drawn gap and holds it until it is accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Lets every awaited result drain, then a few cycles for header bytes in flight.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves valid high so that back-to-back writes never drop it within a step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Rewrites all three registers once the block is idle; unused bits carry noise.
    task automatic set_config(input logic [7:0] ver, input logic [31:0] lim,
                              input logic [63:0] mask, input bit stray);
        logic [CFG_IDX_W-1:0] idx;
        wait_idle();
        if (stray) begin
            idx = CFG_IDX_W'($urandom_range(CFG_KNOWN_TYPE_MASK + 1, 255));
            cfg_write(idx, {$urandom, $urandom});
        end
        cfg_write(CFG_PROTOCOL_VERSION, {$urandom, 24'($urandom), ver});
        cfg_write(CFG_MAX_PAYLOAD, {$urandom, lim});
        cfg_write(CFG_KNOWN_TYPE_MASK, mask);
        cfg_valid   <= 1'b0;
        cur_version = ver;
        cur_limit   = lim;
        cur_mask    = mask;
    endtask

    task automatic fill_body(input int unsigned len);
        for (int i = 0; i < len; i++) begin
            body_buf[i] = 8'($urandom_range(0, 255));
        end
    endtask

    // A header the block accepts under the current registers, random content.
    function automatic t_header framed_header(input logic [31:0] len);
        t_header     h;
        logic [31:0] crc;
        int          t;
        h.magic   = MAGIC_WORD;
        h.version = cur_version;
        t = $urandom_range(0, 63);
        while (!cur_mask[t]) t = $urandom_range(0, 63);
        h.ptype  = 8'(t);
        h.flags  = 16'($urandom);
        h.length = len;
        h.seq    = {$urandom, $urandom};
        h.ts     = {$urandom, $urandom};
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            crc = pdf_pkg::crc_byte(crc, body_buf[i]);
        end
        h.crc = ~crc;
        return h;
    endfunction

    task automatic send_frame(input t_header h, input int unsigned nbody);
        logic [HDR_W-1:0] bits;
        bits = h;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            send_byte(bits[HDR_W-1-8*i -: 8]);
        end
        for (int i = 0; i < nbody; i++) begin
            send_byte(body_buf[i]);
        end
    endtask

    initial begin
        t_header     h;
        logic [31:0] len;
        logic [31:0] lim;
        t_err        fault;
        int          t;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: lowest header values with an empty payload.
        h = framed_header(0);
        h.ptype = 8'd0;
        h.flags = '0;
        h.seq   = '0;
        h.ts    = '0;
        send_frame(h, 0);

        // Highest type of the reset mask, one all-ones payload byte and header.
        body_buf[0] = 8'hFF;
        h = framed_header(1);
        h.ptype = 8'd16;
        h.flags = '1;
        h.seq   = '1;
        h.ts    = '1;
        send_frame(h, 1);

        // Version zero, no payload allowed, every type below 64 accepted.
        set_config(8'h00, 32'd0, '1, 1'b1);
        h = framed_header(0);
        h.ptype = 8'd63;
        send_frame(h, 0);

        // Version 255 and a payload exactly at the limit.
        set_config(8'hFF, 32'd3, {1'b1, 62'd0, 1'b1}, 1'b0);
        body_buf[0] = 8'h00;
        body_buf[1] = 8'hFF;
        body_buf[2] = 8'h5A;
        h = framed_header(3);
        h.ptype = 8'd63;
        send_frame(h, 3);

        // Largest limit, stray register writes that must change nothing.
        set_config(8'($urandom), 32'hFFFF_FFFF, {$urandom, $urandom} | 64'd1, 1'b1);
        fill_body(2);
        send_frame(framed_header(2), 2);

        // Well-formed frames with random content under changing settings.
        while (bytes_sent < 1000) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       lim = 32'd0;
                    1:       lim = 32'hFFFF_FFFF;
                    2:       lim = $urandom_range(0, 30);
                    default: lim = $urandom;
                endcase
                set_config(8'($urandom), lim,
                           {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63)),
                           $urandom_range(0, 3) == 0);
            end
            rx_quiet  = ($urandom_range(0, 3) == 0);
            res_quiet <= ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300)
                                               : $urandom_range(0, 24);
            if (len > cur_limit) len = cur_limit;
            fill_body(len);
            send_frame(framed_header(len), len);
        end

        // One broken frame; later checks may be broken too, to test precedence.
        set_config(cur_version, $urandom_range(0, 400), cur_mask, 1'b0);
        rx_quiet  = 1'b0;
        res_quiet <= 1'b0;
        fault = t_err'($urandom_range(ERR_MAGIC, ERR_CRC));
        len = $urandom_range(0, 24);
        if (len > cur_limit) len = cur_limit;
        fill_body(len);
        h = framed_header(len);
        if (fault == ERR_MAGIC) begin
            h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
        end
        if (fault == ERR_VERSION || (fault < ERR_VERSION && $urandom_range(0, 1))) begin
            h.version = cur_version ^ 8'($urandom_range(1, 255));
        end
        if (fault == ERR_TYPE || (fault < ERR_TYPE && $urandom_range(0, 1))) begin
            if (&cur_mask || $urandom_range(0, 1)) begin
                h.ptype = 8'($urandom_range(64, 255));
            end else begin
                t = $urandom_range(0, 63);
                while (cur_mask[t]) t = $urandom_range(0, 63);
                h.ptype = 8'(t);
            end
        end
        if (fault == ERR_TOO_LONG || (fault < ERR_TOO_LONG && $urandom_range(0, 1))) begin
            h.length = cur_limit + 1 + ($urandom % (32'hFFFF_FFFF - cur_limit));
        end
        if (fault == ERR_CRC) begin
            h.crc = h.crc ^ (32'd1 << $urandom_range(0, 31));
            send_frame(h, len);
        end else begin
            send_frame(h, 0);
        end

        // Trailing bytes after the error must be swallowed.
        repeat ($urandom_range(16, 40)) send_byte(8'($urandom));

        wait_idle();
        repeat (6) @(posedge clk);
        if (chk_mismatches == 0 && chk_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
